/* design/hrad_pkg.sv */
// Shared types and constants for the Huffman run/amplitude decoder.
package hrad_pkg;

  // Width of code lengths and of the count_entries register.
  localparam int unsigned LEN_W = 5;

  // Reset value of count_entries.
  localparam logic [LEN_W-1:0] CFG_RESET = 5'd17;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_SYMBOL = 2'd1,
    OP_BIT    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Symbol lookup request from the code search to the symbol stage.
  typedef struct packed {
    logic issue;
    logic no_match;
  } lookup_t;

endpackage

/* design/hrad_sym_mem.sv */
// Symbol table: one write port, one registered read port.
module hrad_sym_mem #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [7:0]                 rdata_o
);

  logic [7:0] mem_q [ENTRIES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/hrad_search.sv */
// Canonical code search: count table and the per-length code registers.
module hrad_search #(
  parameter int unsigned MAX_CODE_LEN   = 16,
  parameter int unsigned SYMBOL_ENTRIES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cnt_we_i,
  input  logic [7:0]                        cnt_idx_i,
  input  logic [7:0]                        cnt_val_i,
  input  logic                              step_i,
  input  logic                              bit_i,
  input  logic [hrad_pkg::LEN_W-1:0]        count_entries_i,
  output hrad_pkg::lookup_t                 lookup_o,
  output logic [$clog2(SYMBOL_ENTRIES)-1:0] addr_o
);

  localparam int unsigned CntAw = (MAX_CODE_LEN + 1 > 1) ? $clog2(MAX_CODE_LEN + 1) : 1;
  localparam int unsigned SymAw = $clog2(SYMBOL_ENTRIES);
  localparam logic [hrad_pkg::LEN_W-1:0] MaxLim = hrad_pkg::LEN_W'(MAX_CODE_LEN + 1);
  localparam logic [hrad_pkg::LEN_W-1:0] MinLim = hrad_pkg::LEN_W'(2);

  logic [7:0]                 cnt_q [MAX_CODE_LEN+1];
  logic [15:0]                code_q, code_d;
  logic [15:0]                first_q, first_d;
  logic [15:0]                base_q, base_d;
  logic [hrad_pkg::LEN_W-1:0] len_q, len_d;

  logic [hrad_pkg::LEN_W-1:0] lim, eff_len, next_len;
  logic [7:0]                 cnt;
  logic [15:0]                code_cur, first_sum;
  logic [16:0]                diff, addr_sum;
  logic                       hit, in_range, exhausted;

  always_ff @(posedge clk_i) begin
    if (cnt_we_i && (32'(cnt_idx_i) <= MAX_CODE_LEN)) begin
      cnt_q[cnt_idx_i[CntAw-1:0]] <= cnt_val_i;
    end
  end

  always_comb begin
    if (count_entries_i < MinLim) begin
      lim = MinLim;
    end else if (count_entries_i > MaxLim) begin
      lim = MaxLim;
    end else begin
      lim = count_entries_i;
    end

    if (len_q == '0 || len_q >= lim) begin
      eff_len = lim - hrad_pkg::LEN_W'(1);
    end else begin
      eff_len = len_q;
    end
    next_len = eff_len + hrad_pkg::LEN_W'(1);

    cnt       = cnt_q[eff_len[CntAw-1:0]];
    code_cur  = code_q | 16'(bit_i);
    diff      = {1'b0, code_cur} - {1'b0, first_q};
    hit       = !diff[16] && (diff[15:0] < 16'(cnt));
    addr_sum  = {1'b0, base_q} + {1'b0, diff[15:0]};
    in_range  = 32'(addr_sum) < SYMBOL_ENTRIES;
    exhausted = !hit && (next_len >= lim);
    first_sum = first_q + 16'(cnt);

    lookup_o.issue    = step_i && (hit || exhausted);
    lookup_o.no_match = !(hit && in_range);
    addr_o            = (hit && in_range) ? addr_sum[SymAw-1:0] : '0;

    code_d  = code_q;
    first_d = first_q;
    base_d  = base_q;
    len_d   = len_q;
    if (step_i) begin
      if (hit || exhausted) begin
        // Restart the code for the next symbol.
        code_d  = '0;
        first_d = '0;
        base_d  = '0;
        len_d   = hrad_pkg::LEN_W'(1);
      end else begin
        code_d  = {code_cur[14:0], 1'b0};
        first_d = {first_sum[14:0], 1'b0};
        base_d  = base_q + 16'(cnt);
        len_d   = next_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      first_q <= '0;
      base_q  <= '0;
      len_q   <= hrad_pkg::LEN_W'(1);
    end else begin
      code_q  <= code_d;
      first_q <= first_d;
      base_q  <= base_d;
      len_q   <= len_d;
    end
  end

endmodule

/* design/huffman_run_amplitude_decoder.sv */
// Top level of the bit-serial Huffman run/amplitude decoder.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o  in_op_i, in_index_i, in_value_i, in_bit_req_i
//   out      source     out_valid_o / out_stall_i out_zero_run_o, out_amplitude_o, out_no_match_o
//   cfg      sink       cfg_we_i                 cfg_wdata_i (count_entries)
//
// One beat per cycle while in_stall_o is low. A code bit that completes a symbol stalls
// the input while the symbol memory read returns; each amplitude bit takes one beat.
// Reset restores count_entries to 17 and restarts decoding; the tables keep no reset.
// The input stalls while a finished result waits in the output register under a stall.
module huffman_run_amplitude_decoder #(
  parameter int unsigned MAX_CODE_LEN   = 16,
  parameter int unsigned SYMBOL_ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 in_op_i,
  input  logic [7:0]                 in_index_i,
  input  logic [7:0]                 in_value_i,
  input  logic                       in_bit_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 out_zero_run_o,
  output logic signed [15:0]         out_amplitude_o,
  output logic                       out_no_match_o,
  input  logic                       cfg_we_i,
  input  logic [hrad_pkg::LEN_W-1:0] cfg_wdata_i
);

  localparam int unsigned SymAw = $clog2(SYMBOL_ENTRIES);

  logic [hrad_pkg::LEN_W-1:0] cfg_q;

  logic                accept, op_count, op_symbol, op_bit, step, amp_step;
  hrad_pkg::op_e       op;
  hrad_pkg::lookup_t   lookup;
  logic [SymAw-1:0]    sym_addr;
  logic [7:0]          sym_rdata;

  logic        pend_q, pend_d;
  logic        pend_nm_q, pend_nm_d;
  logic        amp_q, amp_d;
  logic [7:0]  held_sym_q, held_sym_d;
  logic        held_nm_q, held_nm_d;
  logic [14:0] bits_q, bits_d;
  logic [3:0]  rem_q, rem_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  zero_run_q, zero_run_d;
  logic [15:0] amp_out_q, amp_out_d;
  logic        nm_out_q, nm_out_d;

  logic        out_free, load_amp, load_sym, pend_done;
  logic [3:0]  size;
  logic [14:0] bits_next;
  logic [3:0]  rem_next;
  logic [15:0] raw, thr, span, amp_val;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = hrad_pkg::op_e'(in_op_i);

  always_comb begin
    op_count  = 1'b0;
    op_symbol = 1'b0;
    op_bit    = 1'b0;
    unique case (op)
      hrad_pkg::OP_COUNT:  op_count  = accept;
      hrad_pkg::OP_SYMBOL: op_symbol = accept;
      hrad_pkg::OP_BIT:    op_bit    = accept;
      hrad_pkg::OP_NONE:   op_bit    = 1'b0;
      default:             op_bit    = 1'b0;
    endcase
  end

  assign step     = op_bit && !amp_q;
  assign amp_step = op_bit && amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hrad_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  hrad_search #(
    .MAX_CODE_LEN  (MAX_CODE_LEN),
    .SYMBOL_ENTRIES(SYMBOL_ENTRIES)
  ) u_search (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cnt_we_i       (op_count),
    .cnt_idx_i      (in_index_i),
    .cnt_val_i      (in_value_i),
    .step_i         (step),
    .bit_i          (in_bit_req_i),
    .count_entries_i(cfg_q),
    .lookup_o       (lookup),
    .addr_o         (sym_addr)
  );

  hrad_sym_mem #(
    .ENTRIES(SYMBOL_ENTRIES)
  ) u_sym_mem (
    .clk_i  (clk_i),
    .we_i   (op_symbol && (32'(in_index_i) < SYMBOL_ENTRIES)),
    .waddr_i(in_index_i[SymAw-1:0]),
    .wdata_i(in_value_i),
    .re_i   (lookup.issue),
    .raddr_i(sym_addr),
    .rdata_o(sym_rdata)
  );

  // Amplitude bit path and JPEG sign extension.
  always_comb begin
    size      = held_sym_q[3:0];
    bits_next = {bits_q[13:0], in_bit_req_i};
    rem_next  = rem_q - 4'd1;
    raw       = {1'b0, bits_next};
    thr       = 16'd1 << (size - 4'd1);
    span      = (16'd1 << size) - 16'd1;
    amp_val   = (raw < thr) ? (raw - span) : raw;
  end

  assign load_amp  = amp_step && (rem_next == 4'd0);
  assign load_sym  = pend_q && (sym_rdata[3:0] == 4'd0) && out_free;
  assign pend_done = pend_q && ((sym_rdata[3:0] != 4'd0) || out_free);

  always_comb begin
    pend_d     = pend_q;
    pend_nm_d  = pend_nm_q;
    amp_d      = amp_q;
    held_sym_d = held_sym_q;
    held_nm_d  = held_nm_q;
    bits_d     = bits_q;
    rem_d      = rem_q;

    if (lookup.issue) begin
      pend_d    = 1'b1;
      pend_nm_d = lookup.no_match;
    end else if (pend_done) begin
      pend_d = 1'b0;
    end

    // Symbol with a nonzero size: collect its amplitude bits next.
    if (pend_done && (sym_rdata[3:0] != 4'd0)) begin
      amp_d      = 1'b1;
      held_sym_d = sym_rdata;
      held_nm_d  = pend_nm_q;
      bits_d     = '0;
      rem_d      = sym_rdata[3:0];
    end

    if (amp_step) begin
      bits_d = bits_next;
      rem_d  = rem_next;
      if (rem_next == 4'd0) begin
        amp_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    zero_run_d  = zero_run_q;
    amp_out_d   = amp_out_q;
    nm_out_d    = nm_out_q;
    priority if (load_amp) begin
      out_valid_d = 1'b1;
      zero_run_d  = held_sym_q[7:4];
      amp_out_d   = amp_val;
      nm_out_d    = held_nm_q;
    end else if (load_sym) begin
      out_valid_d = 1'b1;
      zero_run_d  = sym_rdata[7:4];
      amp_out_d   = '0;
      nm_out_d    = pend_nm_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_nm_q   <= 1'b0;
      amp_q       <= 1'b0;
      held_sym_q  <= '0;
      held_nm_q   <= 1'b0;
      bits_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      pend_nm_q   <= pend_nm_d;
      amp_q       <= amp_d;
      held_sym_q  <= held_sym_d;
      held_nm_q   <= held_nm_d;
      bits_q      <= bits_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_run_q <= zero_run_d;
    amp_out_q  <= amp_out_d;
    nm_out_q   <= nm_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_zero_run_o  = zero_run_q;
  assign out_amplitude_o = amp_out_q;
  assign out_no_match_o  = nm_out_q;

endmodule
